/* rtl/core/clnif_pkg.sv */
`timescale 1ns / 1ps

package clnif_pkg;

	// Request codes carried in the action field.
	localparam logic [2:0] ACT_WRITE_CHAR = 3'd0;
	localparam logic [2:0] ACT_RAW_CMD    = 3'd1;
	localparam logic [2:0] ACT_MOVE       = 3'd2;
	localparam logic [2:0] ACT_CLEAR      = 3'd3;
	localparam logic [2:0] ACT_INIT       = 3'd4;

	// Configuration register indexes.
	localparam int unsigned CFG_INDEX_W = 3;
	localparam int unsigned CFG_DATA_W  = 7;
	localparam logic [CFG_INDEX_W-1:0] CFG_LINE_COUNT  = 3'd0;
	localparam logic [CFG_INDEX_W-1:0] CFG_COL_COUNT   = 3'd1;
	localparam logic [CFG_INDEX_W-1:0] CFG_LINE1_START = 3'd2;
	localparam logic [CFG_INDEX_W-1:0] CFG_LINE2_START = 3'd3;
	localparam logic [CFG_INDEX_W-1:0] CFG_LINE3_START = 3'd4;
	localparam logic [CFG_INDEX_W-1:0] CFG_LINE4_START = 3'd5;

	// Configuration reset values.
	localparam logic [2:0] RST_LINE_COUNT  = 3'd2;
	localparam logic [6:0] RST_COL_COUNT   = 7'd16;
	localparam logic [6:0] RST_LINE1_START = 7'h00;
	localparam logic [6:0] RST_LINE2_START = 7'h40;
	localparam logic [6:0] RST_LINE3_START = 7'h14;
	localparam logic [6:0] RST_LINE4_START = 7'h54;

	// Display command bytes.
	localparam logic [7:0] DDRAM_BASE     = 8'h80;
	localparam logic [7:0] CMD_CLEAR      = 8'h01;
	localparam logic [7:0] CMD_DISPLAY_OFF = 8'h08;
	localparam logic [7:0] CMD_ENTRY_MODE = 8'h06;
	localparam logic [7:0] FUNC_SET_1LINE = 8'h20;
	localparam logic [7:0] FUNC_SET_2LINE = 8'h28;
	localparam logic [3:0] NIB_WAKE       = 4'h3;
	localparam logic [3:0] NIB_4BIT       = 4'h2;

	// Waits in microseconds.
	localparam logic [13:0] WAIT_CMD_BEFORE = 14'd10;
	localparam logic [13:0] WAIT_CMD_AFTER  = 14'd2010;
	localparam logic [13:0] WAIT_CHR        = 14'd10;
	localparam logic [13:0] WAIT_POWER      = 14'd15000;
	localparam logic [13:0] WAIT_WAKE       = 14'd2000;
	localparam logic [13:0] WAIT_INIT_END   = 14'd4020;

	// Strobe index of the final strobe of an initialization.
	localparam logic [3:0] INIT_LAST = 4'd13;

	typedef struct packed {
		logic [2:0] action;
		logic [7:0] value;
		logic [5:0] target_col;
		logic [1:0] target_line;
	} req_t;

	typedef struct packed {
		logic [3:0]  bus_nibble;
		logic        reg_select;
		logic [13:0] wait_before_us;
		logic [13:0] wait_after_us;
		logic [7:0]  cursor_col;
		logic [1:0]  cursor_line;
		logic        last;
	} strobe_t;

	typedef enum logic [1:0] {
		JOB_CHAR,
		JOB_CMD,
		JOB_INIT
	} job_kind_t;

	// One classified request as it waits between front and back.
	typedef struct packed {
		job_kind_t  kind;
		logic [7:0] byte0;
		logic [7:0] byte1;
		logic       wrap;
		logic [7:0] cur_col;
		logic [1:0] cur_line;
	} job_t;

endpackage

/* rtl/core/char_lcd_nibble_interface_unit.sv */
`timescale 1ns / 1ps

// Character LCD driver for a 4-bit bus. Each request (write character, raw
// command, move cursor, clear or initialize) turns into a list of enable
// strobes, one result transfer per strobe: two for a character or command,
// four for a character that wraps onto the next line (the data byte and then
// a cursor-address command), and fourteen for initialization. Each transfer
// carries the nibble for D7..D4, the register-select bit, the idle time
// needed before and after the strobe, the cursor position after the whole
// request, and a last flag on the request's final strobe. The front end takes
// one request per cycle while the queue is not full, updates the tracked
// cursor and classifies it into a job; a queue of QUEUE_DEPTH jobs sits
// between it and the strobe sequencer, which sends one strobe per cycle while
// the consumer pops and so sets the sustained rate. Request codes 5 to 7 are
// taken and dropped with no strobes. Configuration writes take effect on the
// next clock and must only be made while no request is in flight.
module char_lcd_nibble_interface_unit import clnif_pkg::*; #(
	parameter int unsigned QUEUE_DEPTH = 2
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   push,
	output logic                   full,
	input  req_t                   req,
	output logic                   empty,
	input  logic                   pop,
	output strobe_t                strobe,
	input  logic                   cfg_write,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data
);

	logic job_push;
	job_t job;
	logic head_valid;
	job_t head_job;
	logic head_pop;

	// Front end: configuration registers, cursor tracking, classification.
	clnif_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.req       (req),
		.full      (full),
		.cfg_write (cfg_write),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.job_push  (job_push),
		.job       (job)
	);

	// The queue decouples request intake from strobe delivery.
	clnif_job_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (job_push),
		.push_job   (job),
		.full       (full),
		.pop        (head_pop),
		.head_valid (head_valid),
		.head_job   (head_job)
	);

	// Back end: walks each job one strobe per cycle into the output register while it is empty or popped.
	clnif_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head_job   (head_job),
		.head_pop   (head_pop),
		.empty      (empty),
		.pop        (pop),
		.strobe     (strobe)
	);

endmodule

/* rtl/core/clnif_front.sv */
`timescale 1ns / 1ps

module clnif_front import clnif_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   push,
	input  req_t                   req,
	input  logic                   full,
	input  logic                   cfg_write,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data,
	output logic                   job_push,
	output job_t                   job
);

	logic [2:0] line_count_q;
	logic [6:0] col_count_q;
	logic [6:0] line_start_q [4];
	logic [7:0] cursor_col_q;
	logic [1:0] cursor_line_q;

	logic       accept;
	logic       job_valid;
	logic [2:0] next_row3;
	logic [1:0] wrap_row;
	logic [7:0] col_inc;
	logic       wrap;
	logic [1:0] sel_line;
	logic [7:0] sel_col;
	logic [6:0] start_v;
	logic [7:0] addr;
	logic [7:0] func_set;

	// Lines beyond the configured count fall on the last configured line.
	function automatic logic [1:0] line_index(input logic [2:0] lc, input logic [1:0] line);
		logic [2:0] lim;
		lim = ((lc > 3'd4) ? 3'd4 : lc) - 3'd1;
		if (lc <= 3'd1) begin
			return 2'd0;
		end
		return ({1'b0, line} < lim) ? line : lim[1:0];
	endfunction

	assign accept   = push && !full;
	assign job_push = accept && job_valid;

	always_comb begin
		next_row3 = {1'b0, cursor_line_q} + 3'd1;
		wrap_row  = (next_row3 >= line_count_q || next_row3 > 3'd3) ? 2'd0 : next_row3[1:0];
		col_inc   = cursor_col_q + 8'd1;
		wrap      = col_inc >= {1'b0, col_count_q};
		sel_line  = (req.action == ACT_MOVE) ? req.target_line : wrap_row;
		sel_col   = (req.action == ACT_MOVE) ? {2'b00, req.target_col} : 8'd0;
		start_v   = line_start_q[line_index(line_count_q, sel_line)];
		addr      = DDRAM_BASE + {1'b0, start_v} + sel_col;
		func_set  = (line_count_q == 3'd1) ? FUNC_SET_1LINE : FUNC_SET_2LINE;

		job_valid    = 1'b1;
		job.kind     = JOB_CMD;
		job.byte0    = req.value;
		job.byte1    = addr;
		job.wrap     = 1'b0;
		job.cur_col  = cursor_col_q;
		job.cur_line = cursor_line_q;
		unique case (req.action)
			ACT_WRITE_CHAR: begin
				job.kind     = JOB_CHAR;
				job.wrap     = wrap;
				job.cur_col  = wrap ? 8'd0 : col_inc;
				job.cur_line = wrap ? wrap_row : cursor_line_q;
			end
			ACT_RAW_CMD: begin
				job.kind = JOB_CMD;
			end
			ACT_MOVE: begin
				job.byte0    = addr;
				job.cur_col  = {2'b00, req.target_col};
				job.cur_line = req.target_line;
			end
			ACT_CLEAR: begin
				job.byte0    = CMD_CLEAR;
				job.cur_col  = 8'd0;
				job.cur_line = 2'd0;
			end
			ACT_INIT: begin
				job.kind     = JOB_INIT;
				job.byte1    = func_set;
				job.cur_col  = 8'd0;
				job.cur_line = 2'd0;
			end
			default: begin
				job_valid = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			line_count_q    <= RST_LINE_COUNT;
			col_count_q     <= RST_COL_COUNT;
			line_start_q[0] <= RST_LINE1_START;
			line_start_q[1] <= RST_LINE2_START;
			line_start_q[2] <= RST_LINE3_START;
			line_start_q[3] <= RST_LINE4_START;
			cursor_col_q    <= 8'd0;
			cursor_line_q   <= 2'd0;
		end else begin
			if (cfg_write) begin
				unique case (cfg_index)
					CFG_LINE_COUNT:  line_count_q    <= cfg_data[2:0];
					CFG_COL_COUNT:   col_count_q     <= cfg_data;
					CFG_LINE1_START: line_start_q[0] <= cfg_data;
					CFG_LINE2_START: line_start_q[1] <= cfg_data;
					CFG_LINE3_START: line_start_q[2] <= cfg_data;
					CFG_LINE4_START: line_start_q[3] <= cfg_data;
					default: ;
				endcase
			end
			if (job_push) begin
				cursor_col_q  <= job.cur_col;
				cursor_line_q <= job.cur_line;
			end
		end
	end

	a_clear_homes: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && (req.action == ACT_CLEAR || req.action == ACT_INIT))
		|=> (cursor_col_q == 8'd0 && cursor_line_q == 2'd0))
		else $error("cursor not homed after clear or initialization");

endmodule

/* rtl/core/clnif_job_queue.sv */
`timescale 1ns / 1ps

module clnif_job_queue import clnif_pkg::*; #(
	parameter int unsigned DEPTH = 2
) (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  job_t push_job,
	output logic full,
	input  logic pop,
	output logic head_valid,
	output job_t head_job
);

	localparam int unsigned PTR_W = $clog2(DEPTH);
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);

	job_t             entries_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push;
	logic             do_pop;

	assign full       = count_q == CNT_W'(DEPTH);
	assign head_valid = count_q != '0;
	assign head_job   = entries_q[rd_ptr_q];
	assign do_push    = push && !full;
	assign do_pop     = pop && head_valid;

	always_ff @(posedge clk) begin
		if (do_push) begin
			entries_q[wr_ptr_q] <= push_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !full)
		else $error("job pushed into a full queue");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(DEPTH))
		else $error("job queue count out of range");

endmodule

/* rtl/core/clnif_back.sv */
`timescale 1ns / 1ps

module clnif_back import clnif_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    head_valid,
	input  job_t    head_job,
	output logic    head_pop,
	output logic    empty,
	input  logic    pop,
	output strobe_t strobe
);

	logic [3:0] step_q;
	logic       out_valid_q;
	strobe_t    out_q;
	strobe_t    next_strobe;
	logic       advance;

	// Builds strobe number k of a job.
	function automatic strobe_t make_strobe(input job_t job, input logic [3:0] k);
		strobe_t    s;
		logic [7:0] byte_v;
		logic       is_data;
		logic       hi;
		logic [3:0] k_last;
		s             = '0;
		s.cursor_col  = job.cur_col;
		s.cursor_line = job.cur_line;
		hi            = !k[0];
		byte_v        = job.byte0;
		is_data       = 1'b0;
		k_last        = 4'd1;
		unique case (job.kind)
			JOB_CHAR: begin
				is_data = k[3:1] == 3'd0;
				byte_v  = is_data ? job.byte0 : job.byte1;
				k_last  = job.wrap ? 4'd3 : 4'd1;
			end
			JOB_INIT: begin
				k_last = INIT_LAST;
				case (k[3:1])
					3'd2:    byte_v = job.byte1;
					3'd3:    byte_v = CMD_DISPLAY_OFF;
					3'd4:    byte_v = CMD_CLEAR;
					3'd5:    byte_v = CMD_ENTRY_MODE;
					default: byte_v = job.byte0;
				endcase
			end
			default: begin
				byte_v = job.byte0;
			end
		endcase
		s.bus_nibble     = hi ? byte_v[7:4] : byte_v[3:0];
		s.reg_select     = is_data;
		s.wait_before_us = hi ? WAIT_CMD_BEFORE : 14'd0;
		if (hi) begin
			s.wait_after_us = 14'd0;
		end else begin
			s.wait_after_us = is_data ? WAIT_CHR : WAIT_CMD_AFTER;
		end
		// Wake-up nibbles and the switch to the 4-bit bus.
		if (job.kind == JOB_INIT && k < 4'd4) begin
			s.bus_nibble     = (k == 4'd3) ? NIB_4BIT : NIB_WAKE;
			s.wait_before_us = (k == 4'd0) ? WAIT_POWER : 14'd0;
			s.wait_after_us  = (k == 4'd3) ? 14'd0 : WAIT_WAKE;
		end
		if (job.kind == JOB_INIT && k == INIT_LAST) begin
			s.wait_after_us = WAIT_INIT_END;
		end
		s.last = k == k_last;
		return s;
	endfunction

	assign next_strobe = make_strobe(head_job, step_q);
	assign advance     = head_valid && (!out_valid_q || pop);
	assign head_pop    = advance && next_strobe.last;
	assign empty       = !out_valid_q;
	assign strobe      = out_q;

	always_ff @(posedge clk) begin
		if (advance) begin
			out_q <= next_strobe;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q      <= 4'd0;
			out_valid_q <= 1'b0;
		end else begin
			if (advance) begin
				out_valid_q <= 1'b1;
				step_q      <= next_strobe.last ? 4'd0 : step_q + 4'd1;
			end else if (pop) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	a_step_has_job: assert property (@(posedge clk) disable iff (!arst_n)
		(step_q != 4'd0) |-> head_valid)
		else $error("strobe sequencer mid-job without a job");

	a_step_bound: assert property (@(posedge clk) disable iff (!arst_n)
		step_q <= INIT_LAST)
		else $error("strobe index out of range");

	a_cmd_short: assert property (@(posedge clk) disable iff (!arst_n)
		(head_valid && head_job.kind == JOB_CMD) |-> (step_q < 4'd2))
		else $error("command job ran past two strobes");

endmodule

/* tb/tb.sv */
`timescale 1ns / 1ps

// Testbench for the character LCD nibble interface. Requests go in through a
// queue-style push port and every enable strobe comes back as one result
// transfer. A predictor in this file tracks the cursor and the register
// settings, expands each accepted request into its list of strobes, and the
// monitor compares every popped strobe, field by field, with the oldest one
// still pending.
module tb;
	import clnif_pkg::*;

	// Cycles allowed for a dropped request (codes five to seven) to leave the
	// block before the registers change.
	localparam int DRAIN_CYCLES    = 24;
	localparam int WATCHDOG_LIMIT  = 3000;
	localparam int HOLD_CYCLES     = 300;
	localparam int HOLD_AFTER      = 400;
	localparam int ITEMS_PER_PHASE = 34;
	localparam int MAX_REPORTS     = 100;

	typedef struct packed {
		req_t    r;
		logic    typed;
		strobe_t first;
	} directed_row_t;

	logic                   clk       = 1'b0;
	logic                   arst_n    = 1'b0;
	logic                   push      = 1'b0;
	logic                   full;
	req_t                   req       = '0;
	logic                   empty;
	logic                   pop       = 1'b0;
	strobe_t                strobe;
	logic                   cfg_write = 1'b0;
	logic [CFG_INDEX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0]  cfg_data  = '0;

	// Our own copy of the registers and of the tracked cursor.
	logic [2:0] cfg_lines = RST_LINE_COUNT;
	logic [6:0] cfg_cols  = RST_COL_COUNT;
	logic [6:0] line_start [4];
	logic [7:0] cur_col   = 8'd0;
	logic [1:0] cur_row   = 2'd0;

	strobe_t       expected_strobes [$];
	strobe_t       request_strobes [$];
	directed_row_t directed_rows [$];

	int  requests_sent   = 0;
	int  unused_sent     = 0;
	int  strobes_checked = 0;
	int  mismatches      = 0;
	int  settings_used   = 0;
	int  idle_cycles     = 0;
	bit  send_burst      = 1'b0;
	bit  recv_burst      = 1'b0;
	bit  hold_done       = 1'b0;
	strobe_t want;

	char_lcd_nibble_interface_unit DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.full     (full),
		.req      (req),
		.empty    (empty),
		.pop      (pop),
		.strobe   (strobe),
		.cfg_write(cfg_write),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	// 10 ns clock.
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic req_t make_req(logic [2:0] a, logic [7:0] v, logic [5:0] c,
			logic [1:0] l);
		req_t r;
		r.action      = a;
		r.value       = v;
		r.target_col  = c;
		r.target_line = l;
		return r;
	endfunction

	function automatic strobe_t make_strobe(logic [3:0] nib, logic rs, logic [13:0] wb,
			logic [13:0] wa, logic [7:0] col, logic [1:0] line, logic fin);
		strobe_t s;
		s.bus_nibble     = nib;
		s.reg_select     = rs;
		s.wait_before_us = wb;
		s.wait_after_us  = wa;
		s.cursor_col     = col;
		s.cursor_line    = line;
		s.last           = fin;
		return s;
	endfunction

	// A command byte goes out as two strobes: the short settle time before
	// the high nibble and the long execution time after the low nibble.
	task automatic queue_cmd_byte(input logic [7:0] b);
		request_strobes.push_back(make_strobe(b[7:4], 1'b0, WAIT_CMD_BEFORE, 14'd0,
			8'd0, 2'd0, 1'b0));
		request_strobes.push_back(make_strobe(b[3:0], 1'b0, 14'd0, WAIT_CMD_AFTER,
			8'd0, 2'd0, 1'b0));
	endtask

	// Set-DDRAM-address command. With one line (or none) configured every
	// line maps onto the first start address; lines past the configured count
	// fall on the last configured one, and counts above four act as four.
	// The address wraps at eight bits.
	task automatic queue_cursor_move(input logic [7:0] col, input logic [1:0] line);
		logic [2:0] lc;
		logic [2:0] top;
		logic [1:0] idx;
		logic [7:0] addr;
		lc = cfg_lines;
		if (lc <= 3'd1) begin
			idx = 2'd0;
		end else begin
			if (lc > 3'd4) begin
				lc = 3'd4;
			end
			top = lc - 3'd1;
			idx = ({1'b0, line} < top) ? line : top[1:0];
		end
		addr = DDRAM_BASE + {1'b0, line_start[idx]} + col;
		queue_cmd_byte(addr);
		cur_row = line;
		cur_col = col;
	endtask

	// Expands one accepted request into request_strobes and advances the
	// tracked cursor. Every strobe of a request carries the cursor as it
	// stands once the whole request is done.
	task automatic predict_request(input req_t r);
		logic [7:0] next_col;
		logic [2:0] next_row;
		strobe_t    s;
		int         k;
		request_strobes.delete();
		case (r.action)
			ACT_WRITE_CHAR: begin
				request_strobes.push_back(make_strobe(r.value[7:4], 1'b1, WAIT_CHR, 14'd0,
					8'd0, 2'd0, 1'b0));
				request_strobes.push_back(make_strobe(r.value[3:0], 1'b1, 14'd0, WAIT_CHR,
					8'd0, 2'd0, 1'b0));
				next_col = cur_col + 8'd1;
				cur_col  = next_col;
				// Reaching the column count wraps to column zero of the next
				// line, and past the last line back to the first.
				if (next_col >= {1'b0, cfg_cols}) begin
					next_row = {1'b0, cur_row} + 3'd1;
					if (next_row >= cfg_lines || next_row > 3'd3) begin
						next_row = 3'd0;
					end
					queue_cursor_move(8'd0, next_row[1:0]);
				end
			end
			ACT_RAW_CMD: begin
				// The cursor stays put even for a clear or home byte.
				queue_cmd_byte(r.value);
			end
			ACT_MOVE: begin
				queue_cursor_move({2'b00, r.target_col}, r.target_line);
			end
			ACT_CLEAR: begin
				queue_cmd_byte(CMD_CLEAR);
				cur_col = 8'd0;
				cur_row = 2'd0;
			end
			ACT_INIT: begin
				request_strobes.push_back(make_strobe(NIB_WAKE, 1'b0, WAIT_POWER, WAIT_WAKE,
					8'd0, 2'd0, 1'b0));
				request_strobes.push_back(make_strobe(NIB_WAKE, 1'b0, 14'd0, WAIT_WAKE,
					8'd0, 2'd0, 1'b0));
				request_strobes.push_back(make_strobe(NIB_WAKE, 1'b0, 14'd0, WAIT_WAKE,
					8'd0, 2'd0, 1'b0));
				request_strobes.push_back(make_strobe(NIB_4BIT, 1'b0, 14'd0, 14'd0,
					8'd0, 2'd0, 1'b0));
				queue_cmd_byte((cfg_lines == 3'd1) ? FUNC_SET_1LINE : FUNC_SET_2LINE);
				queue_cmd_byte(CMD_DISPLAY_OFF);
				queue_cmd_byte(CMD_CLEAR);
				queue_cmd_byte(CMD_ENTRY_MODE);
				queue_cmd_byte(r.value);
				// The attribute byte closes the sequence with a doubled wait.
				s = request_strobes.pop_back();
				s.wait_after_us = WAIT_INIT_END;
				request_strobes.push_back(s);
				cur_col = 8'd0;
				cur_row = 2'd0;
			end
			default: begin
				// Unused codes are taken and dropped without any strobe.
			end
		endcase
		for (k = 0; k < request_strobes.size(); k++) begin
			s             = request_strobes[k];
			s.cursor_col  = cur_col;
			s.cursor_line = cur_row;
			s.last        = (k == request_strobes.size() - 1);
			request_strobes[k] = s;
		end
	endtask

	// Offers one request after a random gap and holds it until the transfer
	// happens. The expected strobes are worked out at the accepting edge. A
	// typed row replaces the predicted first strobe with the value written
	// into the directed table.
	task automatic send_request(input req_t r, input logic typed, input strobe_t first);
		int      gap;
		logic    accepted;
		strobe_t s;
		gap = send_burst ? 0 : $urandom_range(0, 5);
		if ($urandom_range(0, 19) == 0) begin
			send_burst = !send_burst;
		end
		if (gap != 0) begin
			push <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		push <= 1'b1;
		req  <= r;
		accepted = 1'b0;
		while (!accepted) begin
			@(posedge clk);
			accepted = !full;
			if (accepted) begin
				predict_request(r);
				if (typed) begin
					s = request_strobes.pop_front();
					request_strobes.push_front(first);
				end
				while (request_strobes.size() != 0) begin
					expected_strobes.push_back(request_strobes.pop_front());
				end
				if (r.action <= ACT_INIT) begin
					requests_sent++;
				end else begin
					unused_sent++;
				end
			end
			@(negedge clk);
		end
	endtask

	function automatic req_t random_request();
		req_t       r;
		int         pick;
		logic [2:0] offs;
		logic [6:0] near;
		r.value       = 8'($urandom);
		r.target_col  = 6'($urandom);
		r.target_line = 2'($urandom);
		pick = $urandom_range(0, 99);
		if (pick < 45) begin
			r.action = ACT_WRITE_CHAR;
		end else if (pick < 57) begin
			r.action = ACT_RAW_CMD;
		end else if (pick < 77) begin
			r.action = ACT_MOVE;
			// Half the moves land on the last visible column, so that the
			// next character wraps.
			if ($urandom_range(0, 1) == 1) begin
				near = (cfg_cols == 7'd0) ? 7'd0 : cfg_cols - 7'd1;
				if (near > 7'd63) begin
					near = 7'd63;
				end
				r.target_col = near[5:0];
			end
		end else if (pick < 83) begin
			r.action = ACT_CLEAR;
		end else if (pick < 90) begin
			r.action = ACT_INIT;
		end else begin
			offs = 3'($urandom_range(1, 3));
			r.action = ACT_INIT + offs;
		end
		return r;
	endfunction

	task automatic run_random_items(input int n);
		int   counted;
		req_t r;
		counted = 0;
		while (counted < n) begin
			r = random_request();
			send_request(r, 1'b0, '0);
			if (r.action <= ACT_INIT) begin
				counted++;
			end
		end
		push <= 1'b0;
	endtask

	// Waits until every expected strobe has come back, then gives a dropped
	// request time to leave the block.
	task automatic wait_idle();
		while (expected_strobes.size() != 0) begin
			@(negedge clk);
		end
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	task automatic write_register(input logic [CFG_INDEX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] data);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		case (idx)
			CFG_LINE_COUNT:  cfg_lines = data[2:0];
			CFG_COL_COUNT:   cfg_cols = data;
			CFG_LINE1_START: line_start[0] = data;
			CFG_LINE2_START: line_start[1] = data;
			CFG_LINE3_START: line_start[2] = data;
			CFG_LINE4_START: line_start[3] = data;
			default: begin
			end
		endcase
		@(negedge clk);
	endtask

	task automatic apply_setting(input logic [2:0] lc, input logic [6:0] cc,
			input logic [6:0] s1, input logic [6:0] s2, input logic [6:0] s3,
			input logic [6:0] s4);
		wait_idle();
		write_register(CFG_LINE_COUNT, {4'd0, lc});
		write_register(CFG_COL_COUNT, cc);
		write_register(CFG_LINE1_START, s1);
		write_register(CFG_LINE2_START, s2);
		write_register(CFG_LINE3_START, s3);
		write_register(CFG_LINE4_START, s4);
		cfg_write <= 1'b0;
		settings_used++;
	endtask

	task automatic add_row(input req_t r, input logic typed, input strobe_t first);
		directed_row_t row;
		row.r     = r;
		row.typed = typed;
		row.first = first;
		directed_rows.push_back(row);
	endtask

	task automatic compare_field(input string name, input logic [13:0] e,
			input logic [13:0] a);
		if (e !== a) begin
			mismatches++;
			if (mismatches <= MAX_REPORTS) begin
				$display("%0t: strobe %0d field %s expected %0d actual %0d",
					$time, strobes_checked, name, e, a);
			end
		end
	endtask

	// Result monitor: every popped strobe is checked against the oldest one
	// still pending. Sampling happens at the rising edge, before the block
	// updates its outputs for the next cycle.
	always @(posedge clk) begin
		if (arst_n && pop && !empty) begin
			if (expected_strobes.size() == 0) begin
				mismatches++;
				if (mismatches <= MAX_REPORTS) begin
					$display("%0t: strobe %0d with nothing pending, expected none actual %h",
						$time, strobes_checked, strobe);
				end
			end else begin
				want = expected_strobes.pop_front();
				compare_field("bus_nibble", {10'd0, want.bus_nibble}, {10'd0, strobe.bus_nibble});
				compare_field("reg_select", {13'd0, want.reg_select}, {13'd0, strobe.reg_select});
				compare_field("wait_before_us", want.wait_before_us, strobe.wait_before_us);
				compare_field("wait_after_us", want.wait_after_us, strobe.wait_after_us);
				compare_field("cursor_col", {6'd0, want.cursor_col}, {6'd0, strobe.cursor_col});
				compare_field("cursor_line", {12'd0, want.cursor_line},
					{12'd0, strobe.cursor_line});
				compare_field("last", {13'd0, want.last}, {13'd0, strobe.last});
			end
			strobes_checked++;
		end
	end

	// Watchdog: counts cycles without any transfer on either side.
	always @(posedge clk) begin
		if ((push && !full) || (pop && !empty)) begin
			idle_cycles = 0;
		end else begin
			idle_cycles++;
		end
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("%0t: no transfer for %0d cycles, %0d strobes still pending",
				$time, idle_cycles, expected_strobes.size());
			$display("== FAIL ==");
			$finish;
		end
	end

	// Receiver: random gaps between pops, with bursts of back-to-back pops.
	// Once, well into the run, it stops popping for a long stretch so that
	// the job queue fills and full holds the sender off.
	initial begin : receiver
		int   gap;
		logic got;
		while (!arst_n) begin
			@(negedge clk);
		end
		forever begin
			if (!hold_done && strobes_checked >= HOLD_AFTER) begin
				pop <= 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
				hold_done = 1'b1;
			end
			gap = recv_burst ? 0 : $urandom_range(0, 5);
			if ($urandom_range(0, 19) == 0) begin
				recv_burst = !recv_burst;
			end
			if (gap != 0) begin
				pop <= 1'b0;
				repeat (gap) @(negedge clk);
			end
			pop <= 1'b1;
			got = 1'b0;
			while (!got) begin
				@(posedge clk);
				got = !empty;
				@(negedge clk);
			end
		end
	end

	initial begin : stimulus
		line_start[0] = RST_LINE1_START;
		line_start[1] = RST_LINE2_START;
		line_start[2] = RST_LINE3_START;
		line_start[3] = RST_LINE4_START;

		// Directed table, run with the reset settings. Typed rows carry the
		// first strobe as it reads straight off the sequence definitions.
		add_row(make_req(ACT_INIT, 8'h00, 6'd0, 2'd0), 1'b1,
			make_strobe(NIB_WAKE, 1'b0, WAIT_POWER, WAIT_WAKE, 8'd0, 2'd0, 1'b0));
		add_row(make_req(ACT_RAW_CMD, 8'h00, 6'd0, 2'd0), 1'b1,
			make_strobe(4'h0, 1'b0, WAIT_CMD_BEFORE, 14'd0, 8'd0, 2'd0, 1'b0));
		add_row(make_req(ACT_RAW_CMD, 8'hFF, 6'd63, 2'd3), 1'b1,
			make_strobe(4'hF, 1'b0, WAIT_CMD_BEFORE, 14'd0, 8'd0, 2'd0, 1'b0));
		add_row(make_req(ACT_INIT, 8'hFF, 6'd63, 2'd3), 1'b0, '0);
		add_row(make_req(ACT_WRITE_CHAR, 8'h41, 6'd0, 2'd0), 1'b0, '0);
		add_row(make_req(ACT_WRITE_CHAR, 8'hFF, 6'd0, 2'd0), 1'b0, '0);
		// Raw clear and home bytes leave the tracked cursor where it was.
		add_row(make_req(ACT_RAW_CMD, CMD_CLEAR, 6'd0, 2'd0), 1'b0, '0);
		add_row(make_req(ACT_RAW_CMD, 8'h02, 6'd0, 2'd0), 1'b0, '0);
		add_row(make_req(ACT_CLEAR, 8'h00, 6'd0, 2'd0), 1'b1,
			make_strobe(4'h0, 1'b0, WAIT_CMD_BEFORE, 14'd0, 8'd0, 2'd0, 1'b0));
		add_row(make_req(ACT_WRITE_CHAR, 8'hFF, 6'd0, 2'd0), 1'b1,
			make_strobe(4'hF, 1'b1, WAIT_CHR, 14'd0, 8'd1, 2'd0, 1'b0));
		add_row(make_req(ACT_WRITE_CHAR, 8'h00, 6'd0, 2'd0), 1'b0, '0);
		// The highest address that the reset start addresses reach.
		add_row(make_req(ACT_MOVE, 8'h00, 6'd63, 2'd3), 1'b0, '0);
		add_row(make_req(ACT_MOVE, 8'hFF, 6'd0, 2'd0), 1'b0, '0);
		// Last column of the second line; the character wraps to line zero.
		add_row(make_req(ACT_MOVE, 8'h00, 6'd15, 2'd1), 1'b0, '0);
		add_row(make_req(ACT_WRITE_CHAR, 8'h5A, 6'd0, 2'd0), 1'b0, '0);
		add_row(make_req(ACT_MOVE, 8'h00, 6'd15, 2'd0), 1'b0, '0);
		add_row(make_req(ACT_WRITE_CHAR, 8'hA5, 6'd0, 2'd0), 1'b0, '0);
		// Lines beyond the configured count use the last configured start.
		add_row(make_req(ACT_MOVE, 8'h00, 6'd21, 2'd2), 1'b0, '0);
		add_row(make_req(ACT_MOVE, 8'h00, 6'd7, 2'd3), 1'b0, '0);
		add_row(make_req(ACT_INIT + 3'd1, 8'hFF, 6'd63, 2'd3), 1'b0, '0);
		add_row(make_req(ACT_INIT + 3'd2, 8'h00, 6'd0, 2'd0), 1'b0, '0);
		add_row(make_req(ACT_INIT + 3'd3, 8'h55, 6'd21, 2'd1), 1'b0, '0);
		add_row(make_req(ACT_INIT, 8'h0C, 6'd0, 2'd0), 1'b0, '0);
		add_row(make_req(ACT_WRITE_CHAR, 8'h20, 6'd0, 2'd0), 1'b0, '0);

		repeat (9) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		foreach (directed_rows[i]) begin
			send_request(directed_rows[i].r, directed_rows[i].typed, directed_rows[i].first);
		end
		push <= 1'b0;

		// Random phases over a series of settings: reset values written back,
		// one line with a wrap on every character, four lines of 64 columns with every
		// start at its top, the zero counts, and random mixes.
		apply_setting(RST_LINE_COUNT, RST_COL_COUNT, RST_LINE1_START, RST_LINE2_START,
			RST_LINE3_START, RST_LINE4_START);
		run_random_items(ITEMS_PER_PHASE);
		apply_setting(3'd1, 7'd1, 7'h00, 7'h40, 7'h14, 7'h54);
		run_random_items(ITEMS_PER_PHASE);
		apply_setting(3'd4, 7'd64, 7'h7F, 7'h7F, 7'h7F, 7'h7F);
		run_random_items(ITEMS_PER_PHASE);
		apply_setting(3'd0, 7'd0, 7'h00, 7'h00, 7'h00, 7'h00);
		run_random_items(ITEMS_PER_PHASE);
		apply_setting(3'd3, 7'd20, 7'h00, 7'h40, 7'h14, 7'h54);
		run_random_items(ITEMS_PER_PHASE);
		apply_setting(3'd7, 7'd127, 7'h7F, 7'h00, 7'h55, 7'h2A);
		run_random_items(ITEMS_PER_PHASE);
		apply_setting(3'd5, 7'd2, 7'($urandom), 7'($urandom), 7'($urandom), 7'($urandom));
		run_random_items(ITEMS_PER_PHASE);
		apply_setting(3'($urandom),
			($urandom_range(0, 3) == 0) ? 7'($urandom) : 7'($urandom_range(1, 24)),
			7'($urandom), 7'($urandom), 7'($urandom), 7'($urandom));
		run_random_items(ITEMS_PER_PHASE);

		wait_idle();

		$display("Run covered %0d requests and %0d dropped codes over %0d register settings.",
			requests_sent, unused_sent, settings_used + 1);
		$display("%0d strobes compared, %0d mismatches, one long receiver stall with full input.",
			strobes_checked, mismatches);
		if (mismatches == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule

/* files.f */
rtl/core/clnif_pkg.sv
rtl/core/clnif_front.sv
rtl/core/clnif_job_queue.sv
rtl/core/clnif_back.sv
rtl/core/char_lcd_nibble_interface_unit.sv
tb/tb.sv
